### rtl/slid_pkg.sv
// types, codes and constants shared by the sorted list unit
`timescale 1ns / 1ps

package slid_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_DUMP   = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] entry;
        logic [4:0]               count;
        logic                     last;
    } out_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

### rtl/slid_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module slid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/slid_cmp.sv
// shared two's complement signed compare of a stored entry against the operand
`timescale 1ns / 1ps

module slid_cmp (
    input  logic signed [slid_pkg::DATA_W-1:0] a,
    input  logic signed [slid_pkg::DATA_W-1:0] b,
    output slid_pkg::cmp_res_t                 res
);

    import slid_pkg::*;

    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

### rtl/sorted_list_insert_delete_unit.sv
// sorted list unit: sequencer over one entry ram and one shared comparator
// insert compares from the top down, moving entries up; delete compares from the
// bottom up, then moves entries down; dump reads out each entry in turn; full/empty
// and nop skip the steps; one ram read and one compare per step pair, busy meanwhile
// results appear for one cycle on done and cannot be stalled
// rst_n clears the sequencer and the entry count; ram contents stay undefined
`timescale 1ns / 1ps

module sorted_list_insert_delete_unit #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  slid_pkg::in_t  cmd,
    output logic           done,
    output slid_pkg::out_t result
);

    import slid_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_CMP,
        S_SHL_RD,
        S_SHL_WR,
        S_DMP_RD,
        S_DMP_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    in_t                op_reg, op_next;
    logic               done_reg, done_next;
    out_t               result_reg, result_next;

    logic [CW-1:0]      idx_inc, idx_dec;
    logic [CW+4:0]      count_wide_next;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [DATA_W-1:0]  ram_wdata, ram_rdata;
    cmp_res_t           cmp;

    slid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    slid_cmp u_cmp (
        .a   (ram_rdata),
        .b   (op_reg.value),
        .res (cmp)
    );

    assign idx_inc         = idx_reg + CW'(1);
    assign idx_dec         = idx_reg - CW'(1);
    assign count_wide_next = (CW + 5)'(count_next);

    always_comb
    begin
        unique case (state_reg)
            S_INS_RD:
            begin
                ram_raddr = idx_dec[AW-1:0];
            end
            default:
            begin
                ram_raddr = idx_reg[AW-1:0];
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = op_reg.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = cmd;
                    unique case (cmd.func)
                        FUNC_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_FULL;
                                result_next.entry  = cmd.value;
                                result_next.last   = 1'b1;
                            end
                            else
                            begin
                                idx_next = count_reg;
                                if (count_reg == '0)
                                begin
                                    state_next = S_INS_PUT;
                                end
                                else
                                begin
                                    state_next = S_INS_RD;
                                end
                            end
                        end
                        FUNC_DELETE:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_NOT_FOUND;
                                result_next.entry  = cmd.value;
                                result_next.last   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DEL_RD;
                            end
                        end
                        FUNC_DUMP:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_EMPTY;
                                result_next.entry  = '0;
                                result_next.last   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DMP_RD;
                            end
                        end
                        FUNC_NOP:
                        begin
                            done_next          = 1'b1;
                            result_next.status = ST_OK;
                            result_next.entry  = cmd.value;
                            result_next.last   = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                // move the larger or equal entry up one slot
                if (cmp.lt)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    idx_next  = idx_dec;
                    if (idx_reg == CW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_PUT:
            begin
                ram_we             = 1'b1;
                ram_wdata          = op_reg.value;
                count_next         = count_reg + CW'(1);
                done_next          = 1'b1;
                result_next.status = ST_OK;
                result_next.entry  = op_reg.value;
                result_next.last   = 1'b1;
                state_next         = S_IDLE;
            end
            S_DEL_RD:
            begin
                state_next = S_DEL_CMP;
            end
            S_DEL_CMP:
            begin
                if (cmp.eq)
                begin
                    if (idx_inc == count_reg)
                    begin
                        count_next         = count_reg - CW'(1);
                        done_next          = 1'b1;
                        result_next.status = ST_OK;
                        result_next.entry  = op_reg.value;
                        result_next.last   = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_SHL_RD;
                    end
                end
                else if (cmp.lt && (idx_inc != count_reg))
                begin
                    idx_next   = idx_inc;
                    state_next = S_DEL_RD;
                end
                else
                begin
                    done_next          = 1'b1;
                    result_next.status = ST_NOT_FOUND;
                    result_next.entry  = op_reg.value;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_SHL_RD:
            begin
                state_next = S_SHL_WR;
            end
            S_SHL_WR:
            begin
                // close the gap by moving the entry down one slot
                ram_we    = 1'b1;
                ram_waddr = idx_dec[AW-1:0];
                ram_wdata = ram_rdata;
                if (idx_inc == count_reg)
                begin
                    count_next         = count_reg - CW'(1);
                    done_next          = 1'b1;
                    result_next.status = ST_OK;
                    result_next.entry  = op_reg.value;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SHL_RD;
                end
            end
            S_DMP_RD:
            begin
                state_next = S_DMP_OUT;
            end
            S_DMP_OUT:
            begin
                done_next          = 1'b1;
                result_next.status = ST_OK;
                result_next.entry  = ram_rdata;
                result_next.last   = (idx_inc == count_reg);
                idx_next           = idx_inc;
                if (idx_inc == count_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_next.count = count_wide_next[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            op_reg     <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            op_reg     <= op_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/slid_checker.sv
// port level checks for the sorted list unit, bound to the top level
`timescale 1ns / 1ps

module slid_checker #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input slid_pkg::out_t result
);

    import slid_pkg::*;

    // an accepted command either answers at once or keeps the unit busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither answered nor running");

    // the final beat of a command frees the unit
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |-> !busy)
        else $error("busy held after final beat");

    // a dump beat that is not the final one leaves the unit running
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> (busy && result.status == ST_OK))
        else $error("non-final beat without a running dump");

    // empty status only on a single beat with nothing held
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> (result.count == '0 && result.last))
        else $error("empty status with entries or further beats");

    // count never exceeds the capacity where the field does not wrap
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((CAPACITY > 31) || (int'(result.count) <= CAPACITY)))
        else $error("count above capacity");

endmodule

bind sorted_list_insert_delete_unit slid_checker #(
    .CAPACITY (CAPACITY)
) u_slid_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
